FILE: rtl/bridge_mass_spring_step_defines.svh
// ---------------------------------------------------------------------------
// bridge_mass_spring_step_defines
// Assertion macros shared by the bridge mass-spring block. Under SYNTHESIS
// the macros expand to nothing.
// ---------------------------------------------------------------------------
`ifndef BRIDGE_MASS_SPRING_STEP_DEFINES_SVH
`define BRIDGE_MASS_SPRING_STEP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bms assertion failed");
// next-cycle implication
`define BMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bms assertion failed");
`else
`define BMS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/bms_pkg.sv
// ---------------------------------------------------------------------------
// bms_pkg
// Types, constants and fixed-point helpers of the bridge mass-spring block.
// ---------------------------------------------------------------------------
package bms_pkg;

  // queue depth default
  localparam int QUEUE_DEPTH_DEF = 2;

  // configuration reset values, unsigned q16.16
  localparam logic [30:0] INV_MASS_RESET = 31'd437;
  localparam logic [30:0] STIFF_RESET    = 31'd393216;
  localparam logic [30:0] DAMP_RESET     = 31'd655360;

  // cycles from a register change to valid coefficients
  localparam int COEF_LATENCY = 2;

  // q16.16 constants at working width
  localparam logic signed [71:0] ONE_Q16 = 72'sd65536;
  localparam logic signed [71:0] TWO_Q16 = 72'sd131072;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_INVERSE_MASS     = 2'd0,
    REG_BRIDGE_STIFFNESS = 2'd1,
    REG_BRIDGE_DAMPING   = 2'd2
  } reg_index_t;

  // item kinds
  typedef enum logic {
    KIND_SPRING = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  // classified item as it travels through the queue
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] top_pos;
    logic signed [32:0] top_vel;
    logic signed [31:0] bottom_pos;
    logic signed [32:0] bottom_vel;
    logic [30:0]        stiffness;
    logic [30:0]        damping;
  } entry_t;

  // coefficients handed to the execute stage
  typedef struct packed {
    logic               ready;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [30:0]        inv_mass;
  } coef_t;

  // q32 product to q16: magnitude rounded half up, sign kept
  function automatic logic signed [71:0] round_q16(input logic signed [71:0] p);
    logic signed [71:0] bias;
    bias = p[71] ? 72'sd32767 : 72'sd32768;
    return (p + bias) >>> 16;
  endfunction

  // saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

FILE: rtl/bms_front.sv
// ---------------------------------------------------------------------------
// bms_front
// Input stage: takes item transactions, decodes the operation and forms
// the string end velocities ahead of the queue.
// ---------------------------------------------------------------------------
module bms_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               operation,
  input  logic signed [31:0] top_pos,
  input  logic signed [31:0] top_prev,
  input  logic signed [31:0] bottom_pos,
  input  logic signed [31:0] bottom_prev,
  input  logic [30:0]        spring_stiffness,
  input  logic [30:0]        spring_damping,
  output bms_pkg::entry_t    ent,
  output logic               ent_valid,
  input  logic               ent_ready
);
  import bms_pkg::*;

  entry_t ent_next;

  // stage frees up when empty or when its entry moves on
  assign item_ready = !ent_valid || ent_ready;

  // classify the item
  always_comb begin
    ent_next = '0;
    if (operation) begin
      ent_next.kind = KIND_TICK;
    end else begin
      ent_next.kind       = KIND_SPRING;
      ent_next.top_pos    = top_pos;
      ent_next.top_vel    = {top_pos[31], top_pos} - {top_prev[31], top_prev};
      ent_next.bottom_pos = bottom_pos;
      ent_next.bottom_vel = {bottom_pos[31], bottom_pos} - {bottom_prev[31], bottom_prev};
      ent_next.stiffness  = spring_stiffness;
      ent_next.damping    = spring_damping;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (item_ready) begin
      ent_valid <= item_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      ent <= ent_next;
    end
  end

endmodule

FILE: rtl/bms_queue.sv
// ---------------------------------------------------------------------------
// bms_queue
// Short queue between the input stage and the execute stage.
// ---------------------------------------------------------------------------
module bms_queue #(
  parameter int DEPTH = bms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bms_pkg::entry_t in_data,
  input  logic            in_valid,
  output logic            in_ready,
  output bms_pkg::entry_t out_data,
  output logic            out_valid,
  input  logic            out_ready
);
  import bms_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = count != FULL;
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

FILE: rtl/bms_coef.sv
// ---------------------------------------------------------------------------
// bms_coef
// Configuration registers and the two-stage update of the bridge
// coefficients a = 2 - (k+z)*im and b = z*im - 1.
// ---------------------------------------------------------------------------
module bms_coef (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output bms_pkg::coef_t coef
);
  import bms_pkg::*;

  localparam logic [1:0] SETTLE = 2'(COEF_LATENCY);

  logic [30:0]        inv_mass;
  logic [30:0]        stiff;
  logic [30:0]        damp;
  logic [31:0]        sum_kz;
  logic signed [65:0] prod_a;
  logic signed [65:0] prod_b;
  logic signed [31:0] a;
  logic signed [31:0] b;
  logic signed [31:0] a_next;
  logic signed [31:0] b_next;
  logic [1:0]         settle;

  assign cfg_ready = 1'b1;
  assign sum_kz    = {1'b0, stiff} + {1'b0, damp};

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass <= INV_MASS_RESET;
      stiff    <= STIFF_RESET;
      damp     <= DAMP_RESET;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_INVERSE_MASS:     inv_mass <= cfg_data[30:0];
        REG_BRIDGE_STIFFNESS: stiff    <= cfg_data[30:0];
        REG_BRIDGE_DAMPING:   damp     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // settle counter, coefficients valid at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE;
    end else if (cfg_valid) begin
      settle <= SETTLE;
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    prod_a <= $signed({2'b00, sum_kz}) * $signed({1'b0, inv_mass});
    prod_b <= $signed({1'b0, damp}) * $signed({1'b0, inv_mass});
  end

  // stage 2: round, offset, saturate
  assign a_next = sat32(TWO_Q16 - round_q16(72'(prod_a)));
  assign b_next = sat32(round_q16(72'(prod_b)) - ONE_Q16);

  always_ff @(posedge clk) begin
    a <= a_next;
    b <= b_next;
  end

  assign coef.ready    = settle == '0;
  assign coef.a        = a;
  assign coef.b        = b;
  assign coef.inv_mass = inv_mass;

endmodule

FILE: rtl/bms_back.sv
// ---------------------------------------------------------------------------
// bms_back
// Execute stage: multiplies into the multiply stage registers, then rounds,
// sums, updates the bridge state and loads and holds the result register.
// ---------------------------------------------------------------------------
`include "bridge_mass_spring_step_defines.svh"

module bms_back (
  input  logic               clk,
  input  logic               rst,
  input  bms_pkg::entry_t    ent,
  input  logic               ent_valid,
  output logic               ent_ready,
  input  bms_pkg::coef_t     coef,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] top_force,
  output logic signed [31:0] bottom_force,
  output logic signed [31:0] bridge_top_pos,
  output logic signed [31:0] bridge_bottom_pos
);
  import bms_pkg::*;

  // bridge state
  logic signed [31:0] pos  [2];
  logic signed [31:0] prev [2];
  logic signed [31:0] fsum [2];

  // multiply stage
  logic               s1_valid;
  kind_t              s1_kind;
  logic signed [65:0] s1_p [4];
  logic signed [63:0] s1_q [2];

  logic               adv;
  logic               can_issue;
  logic               issue;
  logic signed [32:0] stretch_top;
  logic signed [32:0] stretch_bot;
  logic signed [32:0] bvel_top;
  logic signed [32:0] bvel_bot;
  logic signed [33:0] vel_top;
  logic signed [33:0] vel_bot;
  logic signed [31:0] kq;
  logic signed [31:0] zq;
  logic signed [31:0] imq;
  logic signed [33:0] mul_x [4];
  logic signed [31:0] mul_y [4];
  logic signed [65:0] prod  [4];
  logic signed [63:0] prodq [2];

  logic signed [71:0] rp [4];
  logic signed [71:0] rq [2];
  logic signed [71:0] pair_top;
  logic signed [71:0] pair_bot;
  logic signed [31:0] force_top;
  logic signed [31:0] force_bot;
  logic signed [31:0] acc_top;
  logic signed [31:0] acc_bot;
  logic signed [31:0] x_top;
  logic signed [31:0] x_bot;

  // pipeline moves when the result register is free or being taken
  assign adv = !result_valid || result_ready;

  // a tick waits for pending force sums and settled coefficients,
  // a spring waits for a tick ahead of it to write the positions
  always_comb begin
    if (ent.kind == KIND_TICK) begin
      can_issue = !s1_valid && coef.ready;
    end else begin
      can_issue = !(s1_valid && (s1_kind == KIND_TICK));
    end
  end

  assign ent_ready = adv && can_issue;
  assign issue     = ent_valid && ent_ready;

  // spring geometry against the bridge masses
  assign stretch_top = {ent.top_pos[31], ent.top_pos} - {pos[0][31], pos[0]};
  assign stretch_bot = {ent.bottom_pos[31], ent.bottom_pos} - {pos[1][31], pos[1]};
  assign bvel_top    = {pos[0][31], pos[0]} - {prev[0][31], prev[0]};
  assign bvel_bot    = {pos[1][31], pos[1]} - {prev[1][31], prev[1]};
  assign vel_top     = {ent.top_vel[32], ent.top_vel} - {bvel_top[32], bvel_top};
  assign vel_bot     = {ent.bottom_vel[32], ent.bottom_vel} - {bvel_bot[32], bvel_bot};
  assign kq          = $signed({1'b0, ent.stiffness});
  assign zq          = $signed({1'b0, ent.damping});
  assign imq         = $signed({1'b0, coef.inv_mass});

  // shared multiplier operands
  always_comb begin
    if (ent.kind == KIND_TICK) begin
      mul_x[0] = 34'(pos[0]);
      mul_y[0] = coef.a;
      mul_x[1] = 34'(prev[0]);
      mul_y[1] = coef.b;
      mul_x[2] = 34'(pos[1]);
      mul_y[2] = coef.a;
      mul_x[3] = 34'(prev[1]);
      mul_y[3] = coef.b;
    end else begin
      mul_x[0] = 34'(stretch_top);
      mul_y[0] = kq;
      mul_x[1] = vel_top;
      mul_y[1] = zq;
      mul_x[2] = 34'(stretch_bot);
      mul_y[2] = kq;
      mul_x[3] = vel_bot;
      mul_y[3] = zq;
    end
  end

  // multipliers
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = mul_x[i] * mul_y[i];
    end
    prodq[0] = fsum[0] * imq;
    prodq[1] = fsum[1] * imq;
  end

  // multiply stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind <= ent.kind;
      s1_p    <= prod;
      s1_q    <= prodq;
    end
  end

  // round and combine
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rp[i] = round_q16(72'(s1_p[i]));
    end
    rq[0] = round_q16(72'(s1_q[0]));
    rq[1] = round_q16(72'(s1_q[1]));
  end

  assign pair_top  = rp[0] + rp[1];
  assign pair_bot  = rp[2] + rp[3];
  assign force_top = sat32(pair_top);
  assign force_bot = sat32(pair_bot);
  assign acc_top   = sat32(72'(fsum[0]) + 72'(force_top));
  assign acc_bot   = sat32(72'(fsum[1]) + 72'(force_bot));
  assign x_top     = sat32(pair_top + rq[0]);
  assign x_bot     = sat32(pair_bot + rq[1]);

  // bridge state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < 2; m++) begin
        pos[m]  <= '0;
        prev[m] <= '0;
        fsum[m] <= '0;
      end
    end else if (s1_valid && adv) begin
      if (s1_kind == KIND_TICK) begin
        pos[0]  <= x_top;
        pos[1]  <= x_bot;
        prev[0] <= pos[0];
        prev[1] <= pos[1];
        fsum[0] <= '0;
        fsum[1] <= '0;
      end else begin
        fsum[0] <= acc_top;
        fsum[1] <= acc_bot;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s1_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_valid && adv) begin
      if (s1_kind == KIND_TICK) begin
        top_force         <= '0;
        bottom_force      <= '0;
        bridge_top_pos    <= x_top;
        bridge_bottom_pos <= x_bot;
      end else begin
        top_force         <= force_top;
        bottom_force      <= force_bot;
        bridge_top_pos    <= pos[0];
        bridge_bottom_pos <= pos[1];
      end
    end
  end

  // a tick leaves the force sums cleared
  `BMS_ASSERT_NEXT(a_tick_clears_sums, clk, rst, s1_valid && adv && (s1_kind == KIND_TICK), (fsum[0] == 32'sd0) && (fsum[1] == 32'sd0))
  // a tick moves the old positions into the previous ones
  `BMS_ASSERT_NEXT(a_tick_shifts_prev, clk, rst, s1_valid && adv && (s1_kind == KIND_TICK), (prev[0] == $past(pos[0])) && (prev[1] == $past(pos[1])))
  // a spring never moves the bridge masses
  `BMS_ASSERT_NEXT(a_spring_holds_pos, clk, rst, s1_valid && adv && (s1_kind == KIND_SPRING), $stable(pos[0]) && $stable(pos[1]))

endmodule

FILE: rtl/bridge_mass_spring_step.sv
// ---------------------------------------------------------------------------
// bridge_mass_spring_step
// Two bridge masses of a mass-spring-damper string model in q16.16: spring
// transactions add string forces to the bridge, tick transactions advance it.
//
//   channel   handshake                fields
//   item      item_valid / item_ready  operation, string ends, k, z
//   result    result_valid / ready     top_force, bottom_force, bridge pos
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Spring items stream at one per cycle unless results stall or a tick is in
// the multiply stage; each result passes the input stage, the queue, the
// multiply stage and the result register. A tick waits while any item
// is still in the multiply stage, and the spring after a tick waits for the
// new positions. Ticks are held after reset and after any config write while
// the coefficient pipeline settles; spring items are not held.
// Result stalls back up through the execute stage, the queue and the input
// stage; reset is synchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module bridge_mass_spring_step #(
  parameter int QUEUE_DEPTH = bms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               operation,
  input  logic signed [31:0] top_pos,
  input  logic signed [31:0] top_prev,
  input  logic signed [31:0] bottom_pos,
  input  logic signed [31:0] bottom_prev,
  input  logic [30:0]        spring_stiffness,
  input  logic [30:0]        spring_damping,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] top_force,
  output logic signed [31:0] bottom_force,
  output logic signed [31:0] bridge_top_pos,
  output logic signed [31:0] bridge_bottom_pos,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import bms_pkg::*;

  entry_t front_ent;
  logic   front_valid;
  logic   front_ready;
  entry_t queue_ent;
  logic   queue_valid;
  logic   queue_ready;
  coef_t  coef;

  // input stage
  bms_front u_front (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .operation        (operation),
    .top_pos          (top_pos),
    .top_prev         (top_prev),
    .bottom_pos       (bottom_pos),
    .bottom_prev      (bottom_prev),
    .spring_stiffness (spring_stiffness),
    .spring_damping   (spring_damping),
    .ent              (front_ent),
    .ent_valid        (front_valid),
    .ent_ready        (front_ready)
  );

  // decoupling queue
  bms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_data   (front_ent),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_data  (queue_ent),
    .out_valid (queue_valid),
    .out_ready (queue_ready)
  );

  // configuration and coefficients
  bms_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // execute stage
  bms_back u_back (
    .clk               (clk),
    .rst               (rst),
    .ent               (queue_ent),
    .ent_valid         (queue_valid),
    .ent_ready         (queue_ready),
    .coef              (coef),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .top_force         (top_force),
    .bottom_force      (bottom_force),
    .bridge_top_pos    (bridge_top_pos),
    .bridge_bottom_pos (bridge_bottom_pos)
  );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: bridge mass-spring step testbench
// Drives spring contacts and ticks into bridge_mass_spring_step with random
// gaps and result stalls, tracks both bridge masses in a local fixed-point
// predictor and checks every result transaction field by field, across
// several register settings including the extremes.
// ----------------------------------------------------------------------------
module tb;
  import bms_pkg::*;

  // write to the unused register slot, which changes no register in the block
  localparam logic [1:0]         REG_SPARE = 2'd3;
  localparam logic signed [31:0] POS_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [31:0] POS_MIN   = 32'sh80000000;
  localparam logic [30:0]        COEF_MAX  = 31'h7FFFFFFF;
  localparam longint             Q16_ONE   = 65536;

  typedef struct {
    kind_t              op;
    logic signed [31:0] top_pos;
    logic signed [31:0] top_prev;
    logic signed [31:0] bottom_pos;
    logic signed [31:0] bottom_prev;
    logic [30:0]        k;
    logic [30:0]        z;
  } bridge_item_t;

  typedef struct {
    logic signed [31:0] top_force;
    logic signed [31:0] bottom_force;
    logic signed [31:0] top_mass;
    logic signed [31:0] bottom_mass;
  } bridge_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic               operation = 1'b0;
  logic signed [31:0] top_pos = '0;
  logic signed [31:0] top_prev = '0;
  logic signed [31:0] bottom_pos = '0;
  logic signed [31:0] bottom_prev = '0;
  logic [30:0]        spring_stiffness = '0;
  logic [30:0]        spring_damping = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [31:0] top_force;
  logic signed [31:0] bottom_force;
  logic signed [31:0] bridge_top_pos;
  logic signed [31:0] bridge_bottom_pos;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // predictor copy of registers and bridge state
  logic [30:0] inv_mass_r = INV_MASS_RESET;
  logic [30:0] stiff_r    = STIFF_RESET;
  logic [30:0] damp_r     = DAMP_RESET;
  longint      mass_pos[2]  = '{0, 0};
  longint      mass_prev[2] = '{0, 0};
  longint      force_sum[2] = '{0, 0};

  bridge_result_t expected_results[$];
  int             mismatch_count = 0;
  int             results_checked = 0;
  int             items_sent = 0;
  int             reg_writes = 0;
  bit             feed_gaps = 1'b1;
  bit             sink_stalls = 1'b1;

  bridge_mass_spring_step u_top (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .operation         (operation),
    .top_pos           (top_pos),
    .top_prev          (top_prev),
    .bottom_pos        (bottom_pos),
    .bottom_prev       (bottom_prev),
    .spring_stiffness  (spring_stiffness),
    .spring_damping    (spring_damping),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .top_force         (top_force),
    .bottom_force      (bottom_force),
    .bridge_top_pos    (bridge_top_pos),
    .bridge_bottom_pos (bridge_bottom_pos),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // exact q16.16 product, magnitude rounded half up
  function automatic longint qmul(input longint x, input longint y);
    logic [63:0]  mx;
    logic [63:0]  my;
    logic [127:0] mag;
    longint       r;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    mag = ({64'd0, mx} * {64'd0, my} + 128'h8000) >> 16;
    r = longint'(mag[63:0]);
    return ((x < 0) != (y < 0)) ? -r : r;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // damped spring from one string end to bridge mass m, accumulated
  function automatic longint end_force(input longint k, input longint z,
                                       input longint pos, input longint prev,
                                       input int m);
    longint stretch;
    longint vel;
    longint f;
    stretch = pos - mass_pos[m];
    vel = (pos - prev) - (mass_pos[m] - mass_prev[m]);
    f = clamp32(qmul(stretch, k) + qmul(vel, z));
    force_sum[m] = clamp32(force_sum[m] + f);
    return f;
  endfunction

  function automatic bridge_result_t step_bridge(input bridge_item_t it);
    bridge_result_t r;
    longint         im;
    longint         kb;
    longint         zb;
    longint         a;
    longint         b;
    longint         old;
    r.top_force = '0;
    r.bottom_force = '0;
    if (it.op == KIND_SPRING) begin
      r.top_force = 32'(end_force(longint'(it.k), longint'(it.z),
                                  longint'(it.top_pos), longint'(it.top_prev), 0));
      r.bottom_force = 32'(end_force(longint'(it.k), longint'(it.z),
                                     longint'(it.bottom_pos),
                                     longint'(it.bottom_prev), 1));
    end else begin
      im = longint'(inv_mass_r);
      kb = longint'(stiff_r);
      zb = longint'(damp_r);
      a = clamp32(2 * Q16_ONE - qmul(kb + zb, im));
      b = clamp32(qmul(zb, im) - Q16_ONE);
      for (int m = 0; m < 2; m++) begin
        old = mass_pos[m];
        mass_pos[m] = clamp32(qmul(old, a) + qmul(mass_prev[m], b) +
                              qmul(force_sum[m], im));
        mass_prev[m] = old;
        force_sum[m] = 0;
      end
    end
    r.top_mass = 32'(mass_pos[0]);
    r.bottom_mass = 32'(mass_pos[1]);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch on %s: got %h, expected %h at %0t", what, got, want,
             $realtime);
    mismatch_count++;
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    bridge_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", top_force, '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (top_force !== want.top_force)
          report_mismatch("top_force", top_force, want.top_force);
        if (bottom_force !== want.bottom_force)
          report_mismatch("bottom_force", bottom_force, want.bottom_force);
        if (bridge_top_pos !== want.top_mass)
          report_mismatch("bridge_top_pos", bridge_top_pos, want.top_mass);
        if (bridge_bottom_pos !== want.bottom_mass)
          report_mismatch("bridge_bottom_pos", bridge_bottom_pos, want.bottom_mass);
      end
    end
  end

  // result side: random stall before each transaction
  initial begin : result_sink
    int n;
    forever begin
      n = sink_stalls ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input bridge_item_t it);
    int gap;
    gap = feed_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid       <= 1'b1;
    operation        <= it.op;
    top_pos          <= it.top_pos;
    top_prev         <= it.top_prev;
    bottom_pos       <= it.bottom_pos;
    bottom_prev      <= it.bottom_prev;
    spring_stiffness <= it.k;
    spring_damping   <= it.z;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_results.push_back(step_bridge(it));
    items_sent++;
  endtask

  // stop feeding and let every pending result come back
  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INVERSE_MASS:     inv_mass_r = data[30:0];
      REG_BRIDGE_STIFFNESS: stiff_r = data[30:0];
      REG_BRIDGE_DAMPING:   damp_r = data[30:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_bridge(input logic [31:0] im, input logic [31:0] k,
                                input logic [31:0] z);
    wait_idle();
    write_reg(REG_INVERSE_MASS, im);
    write_reg(REG_BRIDGE_STIFFNESS, k);
    write_reg(REG_BRIDGE_DAMPING, z);
  endtask

  // ---------------------------------------------------------------- items

  function automatic bridge_item_t contact(input logic signed [31:0] tp,
                                           input logic signed [31:0] tpr,
                                           input logic signed [31:0] bp,
                                           input logic signed [31:0] bpr,
                                           input logic [30:0] k,
                                           input logic [30:0] z);
    bridge_item_t it;
    it.op = KIND_SPRING;
    it.top_pos = tp;
    it.top_prev = tpr;
    it.bottom_pos = bp;
    it.bottom_prev = bpr;
    it.k = k;
    it.z = z;
    return it;
  endfunction

  function automatic logic [31:0] any_pos();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 524288) - 262144;
      2: begin
        case ($urandom_range(0, 3))
          0: return POS_MAX;
          1: return POS_MIN;
          2: return 32'd0;
          default: return 32'hFFFFFFFF;
        endcase
      end
      default: return $urandom_range(0, 33554432) - 16777216;
    endcase
  endfunction

  function automatic logic [30:0] any_coef();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 20 << 16));
      2: return $urandom_range(0, 1) ? COEF_MAX : 31'd0;
      default: return 31'($urandom_range(0, 65536));
    endcase
  endfunction

  // anything the fields allow
  function automatic bridge_item_t wild_item();
    return contact(any_pos(), any_pos(), any_pos(), any_pos(), any_coef(),
                   any_coef());
  endfunction

  // plausible string ends: small positions, prev close to pos
  function automatic bridge_item_t calm_item();
    logic [31:0] tp;
    logic [31:0] bp;
    tp = $urandom_range(0, 524288) - 262144;
    bp = $urandom_range(0, 524288) - 262144;
    return contact(tp, tp + $urandom_range(0, 8192) - 4096,
                   bp, bp + $urandom_range(0, 8192) - 4096,
                   31'($urandom_range(0, 16 << 16)), 31'($urandom_range(0, 4 << 16)));
  endfunction

  // tick with junk in the unused fields
  function automatic bridge_item_t tick_item();
    bridge_item_t it;
    it = wild_item();
    it.op = KIND_TICK;
    return it;
  endfunction

  // groups of string contacts closed by a tick, with some broken groups
  task automatic run_contacts(input int count, input bit mix_idle);
    int           sent;
    int           n;
    bridge_item_t it;
    sent = 0;
    while (sent < count) begin
      if (mix_idle) begin
        feed_gaps = 1'($urandom_range(0, 1));
        sink_stalls = 1'($urandom_range(0, 1));
      end
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 6) == 0) it = wild_item();
        else it = calm_item();
        send_item(it);
      end
      if ($urandom_range(0, 9) != 0) send_item(tick_item());
      if ($urandom_range(0, 19) == 0) send_item(tick_item());
      sent += n + 1;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_item(tick_item());
    send_item(contact(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_spring_extremes();
    send_item(contact(POS_MAX, POS_MIN, POS_MIN, POS_MAX, COEF_MAX, COEF_MAX));
    send_item(contact(POS_MIN, POS_MIN, POS_MAX, POS_MAX, COEF_MAX, 31'd0));
    // exact half and just below half of one lsb
    send_item(contact(32'sh8000, 0, -32'sh8000, 0, 31'd1, 31'd0));
    send_item(contact(32'sh7FFF, 0, -32'sh7FFF, 0, 31'd1, 31'd0));
    // damping only
    send_item(contact(0, 32'sh10000, 0, -32'sh10000, 31'd0, 31'h10000));
    send_item(tick_item());
  endtask

  task automatic test_force_saturation();
    repeat (3)
      send_item(contact(POS_MAX, POS_MIN, POS_MAX, POS_MIN, COEF_MAX, COEF_MAX));
    send_item(tick_item());
    repeat (3)
      send_item(contact(POS_MIN, POS_MAX, POS_MIN, POS_MAX, COEF_MAX, COEF_MAX));
    send_item(tick_item());
    send_item(tick_item());
  endtask

  task automatic test_reset_config_stream();
    feed_gaps = 1'b1;
    sink_stalls = 1'b1;
    run_contacts(100, 1'b0);
  endtask

  task automatic test_config_extremes();
    // top bit of the data is dropped by the registers
    program_bridge(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    feed_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_contacts(100, 1'b0);
    program_bridge(32'd0, 32'd0, 32'd0);
    wait_idle();
    write_reg(REG_SPARE, 32'hFFFFFFFF);
    feed_gaps = 1'b1;
    run_contacts(100, 1'b0);
  endtask

  task automatic test_random_settings();
    program_bridge($urandom_range(100, 3000), $urandom_range(0, 20 << 16),
                   $urandom_range(0, 20 << 16));
    feed_gaps = 1'b0;
    sink_stalls = 1'b1;
    run_contacts(150, 1'b0);
    program_bridge($urandom(), $urandom(), $urandom());
    feed_gaps = 1'b1;
    run_contacts(100, 1'b0);
  endtask

  task automatic test_idle_mix();
    program_bridge(32'h80000000 | {1'b0, INV_MASS_RESET},
                   32'h80000000 | {1'b0, STIFF_RESET},
                   32'h80000000 | {1'b0, DAMP_RESET});
    run_contacts(250, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_spring_extremes();
    test_force_saturation();
    test_reset_config_stream();
    test_config_extremes();
    test_random_settings();
    test_idle_mix();
    wait_idle();
    repeat (12) @(posedge clk);
    $display("tb: %0d transactions sent, %0d results checked, %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("tb: covered default, extreme, zero and random bridge settings");
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
